### design/sphcr_pkg.sv
// shared types and constants for the stride and pc hybrid replacement policy
package sphcr_pkg;

    localparam int SETS_DEF  = 2048;
    localparam int WAYS_DEF  = 16;
    localparam int HIST_DEF  = 8;
    localparam int SLOTS_DEF = 32;

    localparam int ADDR_W     = 48;
    localparam int PC_W       = 12;
    localparam int AGE_W      = 8;
    localparam int CNT_W      = 16;
    localparam int STRIDE_W   = 32;
    localparam int SET_IN_W   = 11;
    localparam int WAY_IN_W   = 4;
    localparam int LIMIT_W    = 6;
    localparam int WIN_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int WEIGHT_W   = 3;
    localparam int SCORE_W    = 20;
    localparam int SP_W       = 2;

    localparam logic [AGE_W-1:0] AGE_MAX   = '1;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_FEW_PC  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MANY_PC = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd2;

    localparam logic [LIMIT_W-1:0] FEW_PC_RESET  = 6'd8;
    localparam logic [LIMIT_W-1:0] MANY_PC_RESET = 6'd16;
    localparam logic [WIN_W-1:0]   WINDOW_RESET  = 4'd4;

    localparam logic CMD_FIND   = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;

    localparam logic [SP_W-1:0] SP_EXACT = 2'd0;
    localparam logic [SP_W-1:0] SP_NEAR  = 2'd1;
    localparam logic [SP_W-1:0] SP_FAR   = 2'd2;

    localparam logic [WEIGHT_W-1:0] W_BASE        = 3'd2;
    localparam logic [WEIGHT_W-1:0] W_STRIDE_AGE  = 3'd3;
    localparam logic [WEIGHT_W-1:0] W_STRIDE_SP   = 3'd4;
    localparam logic [WEIGHT_W-1:0] W_STRIDE_PC   = 3'd1;
    localparam logic [WEIGHT_W-1:0] W_MANY_AGE    = 3'd2;
    localparam logic [WEIGHT_W-1:0] W_MANY_SP     = 3'd1;
    localparam logic [WEIGHT_W-1:0] W_MANY_PC     = 3'd4;

    typedef struct packed {
        logic                command;
        logic [SET_IN_W-1:0] set_index;
        logic [WAY_IN_W-1:0] way_index;
        logic [ADDR_W-1:0]   address;
        logic [PC_W-1:0]     pc_low;
    } req_t;

    typedef struct packed {
        logic [WAY_IN_W-1:0] victim_way;
        logic                victim_was_invalid;
    } rsp_t;

endpackage

### design/sphcr_ram.sv
// generic single write port ram with registered read
module sphcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/stride_pc_hybrid_cache_replacement.sv
// top level of the stride and pc hybrid replacement policy
// one request at a time; a find over a set with an invalid way answers without any scan,
// a find over a full set runs the serial slot scan and then the serial way scan, and an
// update with an in range way runs the serial slot scan and the history stride check
// a non power of two set count adds a serial set reduction
// after reset a clearing pass writes every row of the metadata ram before the first beat
module stride_pc_hybrid_cache_replacement #(
    parameter int SETS           = sphcr_pkg::SETS_DEF,
    parameter int WAYS           = sphcr_pkg::WAYS_DEF,
    parameter int HISTORY_DEPTH  = sphcr_pkg::HIST_DEF,
    parameter int PC_TABLE_SLOTS = sphcr_pkg::SLOTS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  sphcr_pkg::req_t                       in_data,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output sphcr_pkg::rsp_t                       out_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [sphcr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sphcr_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import sphcr_pkg::*;

    localparam int SAW = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WIW = $clog2(WAYS);
    localparam int HIW = $clog2(HISTORY_DEPTH);
    localparam int HCW = $clog2(HISTORY_DEPTH + 1);
    localparam int SIW = $clog2(PC_TABLE_SLOTS);
    localparam int UQW = $clog2(PC_TABLE_SLOTS + 1);
    localparam int MCW = $clog2(SET_IN_W);
    localparam int DW  = ADDR_W + 1;
    localparam bit NEED_MOD = ((SETS & (SETS - 1)) != 0) && (SETS < (1 << SET_IN_W));

    typedef struct packed {
        logic [WAYS-1:0]                    valid;
        logic [WAYS-1:0][AGE_W-1:0]         age;
        logic [WAYS-1:0][PC_W-1:0]          pc;
        logic [WAYS-1:0][SP_W-1:0]          spatial;
        logic [HCW-1:0]                     hcount;
        logic [STRIDE_W-1:0]                stride;
        logic [ADDR_W-1:0]                  last;
        logic [PC_TABLE_SLOTS-1:0]          used;
    } meta_t;

    typedef struct packed {
        logic [HISTORY_DEPTH-1:0][ADDR_W-1:0] hist;
        logic [PC_TABLE_SLOTS-1:0][PC_W-1:0]  key;
        logic [PC_TABLE_SLOTS-1:0][CNT_W-1:0] cnt;
    } slot_t;

    typedef enum logic [12:0] {
        S_CLEAR   = 13'b0000000000001,
        S_IDLE    = 13'b0000000000010,
        S_MOD     = 13'b0000000000100,
        S_READ    = 13'b0000000001000,
        S_LOAD    = 13'b0000000010000,
        S_PREP    = 13'b0000000100000,
        S_SCAN    = 13'b0000001000000,
        S_SCORE   = 13'b0000010000000,
        S_COUNT   = 13'b0000100000000,
        S_STRIDE  = 13'b0001000000000,
        S_SPATIAL = 13'b0010000000000,
        S_WRITE   = 13'b0100000000000,
        S_DONE    = 13'b1000000000000
    } state_t;

    state_t                state_reg, state_next;
    logic [SAW-1:0]        clr_cnt_reg;
    logic                  out_valid_reg;
    rsp_t                  out_data_reg;
    logic [LIMIT_W-1:0]    few_reg;
    logic [LIMIT_W-1:0]    many_reg;
    logic [WIN_W-1:0]      win_reg;

    req_t                  req_reg;
    logic [SAW-1:0]        set_reg;
    logic [SAW-1:0]        rem_reg;
    logic [MCW-1:0]        mcnt_reg;
    meta_t                 meta_reg;
    slot_t                 slot_reg;
    logic [SIW-1:0]        scnt_reg;
    logic [WIW-1:0]        wcnt_reg;
    logic [CNT_W-1:0]      maxc_reg;
    logic [WAYS-1:0][CNT_W-1:0] way_cnt_reg;
    logic [WEIGHT_W-1:0]   wa_reg, ws_reg, wp_reg;
    logic [SCORE_W-1:0]    best_reg;
    logic [WIW-1:0]        victim_reg;
    logic                  hit_reg, free_reg;
    logic [SIW-1:0]        hit_idx_reg, free_idx_reg, min_idx_reg;
    logic [CNT_W-1:0]      minc_reg;
    logic [DW-1:0]         d_reg;
    logic [HCW-1:0]        i_reg;
    logic                  ok_reg;
    rsp_t                  res_reg;

    meta_t                 mem_a_rdata, clr_row, mem_a_wdata;
    slot_t                 mem_b_rdata;
    logic                  mem_a_we;
    logic [SAW-1:0]        mem_a_waddr;

    logic                  in_accept;
    logic                  out_free;
    logic [SAW-1:0]        set_direct;
    logic [SAW:0]          mod_wide, mod_sub;
    logic [SAW-1:0]        rem_next;
    logic                  inv_any;
    logic [WIW-1:0]        inv_way;
    logic [UQW-1:0]        uniq;
    logic                  way_oob;
    logic [WIW-1:0]        way_sel;
    logic                  scan_last;
    logic                  score_last;
    logic [SCORE_W-1:0]    score;
    logic [CNT_W-1:0]      pc_gap;
    logic [HIW-1:0]        hi_idx, lo_idx;
    logic [DW-1:0]         step_diff;
    logic                  stride_done;
    logic [DW-1:0]         addr_gap, adist, st_ext;
    logic [STRIDE_W-1:0]   ast;
    logic [WIN_W+STRIDE_W-1:0] prod;
    logic [SP_W-1:0]       sp_code;

    sphcr_ram #(.WIDTH($bits(meta_t)), .DEPTH(SETS)) u_meta_ram (
        .clk   (clk),
        .we    (mem_a_we),
        .waddr (mem_a_waddr),
        .wdata (mem_a_wdata),
        .raddr (set_reg),
        .rdata (mem_a_rdata)
    );

    sphcr_ram #(.WIDTH($bits(slot_t)), .DEPTH(SETS)) u_slot_ram (
        .clk   (clk),
        .we    (state_reg == S_WRITE),
        .waddr (set_reg),
        .wdata (slot_reg),
        .raddr (set_reg),
        .rdata (mem_b_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        clr_row = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            clr_row.age[w] = AGE_MAX;
        end
        mem_a_we    = (state_reg == S_CLEAR) || (state_reg == S_WRITE);
        mem_a_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : set_reg;
        mem_a_wdata = (state_reg == S_CLEAR) ? clr_row : meta_reg;
    end

    // set reduction
    always_comb
    begin
        set_direct = (SETS == 1) ? '0 : SAW'(in_data.set_index);
        mod_wide   = {rem_reg, req_reg.set_index[mcnt_reg]};
        mod_sub    = mod_wide - (SAW + 1)'(SETS);
        rem_next   = (mod_wide >= (SAW + 1)'(SETS)) ? mod_sub[SAW-1:0] : mod_wide[SAW-1:0];
    end

    // first invalid way, distinct pcs, way range
    always_comb
    begin
        inv_any = 1'b0;
        inv_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (!meta_reg.valid[w])
            begin
                inv_any = 1'b1;
                inv_way = WIW'(w);
            end
        end
        uniq = '0;
        for (int s = 0; s < PC_TABLE_SLOTS; s++)
        begin
            uniq = uniq + UQW'(meta_reg.used[s]);
        end
        way_oob = (int'(req_reg.way_index) >= WAYS);
        way_sel = WIW'(req_reg.way_index);
    end

    // scans and stride steps
    always_comb
    begin
        scan_last   = (scnt_reg == SIW'(PC_TABLE_SLOTS - 1));
        score_last  = (wcnt_reg == WIW'(WAYS - 1));
        pc_gap      = maxc_reg - way_cnt_reg[wcnt_reg];
        score       = ({{(SCORE_W-WEIGHT_W){1'b0}}, wa_reg}
                       * {{(SCORE_W-AGE_W){1'b0}}, meta_reg.age[wcnt_reg]})
                    + ({{(SCORE_W-WEIGHT_W){1'b0}}, ws_reg}
                       * {{(SCORE_W-SP_W){1'b0}}, meta_reg.spatial[wcnt_reg]})
                    + ({{(SCORE_W-WEIGHT_W){1'b0}}, wp_reg}
                       * {{(SCORE_W-CNT_W){1'b0}}, pc_gap});
        hi_idx      = i_reg[HIW-1:0];
        lo_idx      = hi_idx - HIW'(1);
        step_diff   = {1'b0, slot_reg.hist[hi_idx]} - {1'b0, slot_reg.hist[lo_idx]};
        stride_done = (meta_reg.hcount < HCW'(3)) || (i_reg >= meta_reg.hcount);
    end

    // spatial score
    always_comb
    begin
        st_ext   = {{(DW-STRIDE_W){meta_reg.stride[STRIDE_W-1]}}, meta_reg.stride};
        addr_gap = {1'b0, req_reg.address} - {1'b0, meta_reg.last};
        adist    = addr_gap[DW-1] ? (-addr_gap) : addr_gap;
        ast      = meta_reg.stride[STRIDE_W-1] ? (-meta_reg.stride) : meta_reg.stride;
        prod     = {{STRIDE_W{1'b0}}, win_reg} * {{WIN_W{1'b0}}, ast};
        if (meta_reg.stride == '0)
        begin
            sp_code = SP_FAR;
        end
        else if (addr_gap == st_ext)
        begin
            sp_code = SP_EXACT;
        end
        else if (adist <= DW'(prod))
        begin
            sp_code = SP_NEAR;
        end
        else
        begin
            sp_code = SP_FAR;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_cnt_reg == SAW'(SETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = NEED_MOD ? S_MOD : S_READ;
                end
            end
            S_MOD:
            begin
                if (mcnt_reg == '0)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:    state_next = S_LOAD;
            S_LOAD:    state_next = S_PREP;
            S_PREP:
            begin
                if (req_reg.command == CMD_FIND)
                begin
                    state_next = inv_any ? S_DONE : S_SCAN;
                end
                else
                begin
                    state_next = way_oob ? S_DONE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = (req_reg.command == CMD_FIND) ? S_SCORE : S_COUNT;
                end
            end
            S_SCORE:
            begin
                if (score_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_COUNT:   state_next = S_STRIDE;
            S_STRIDE:
            begin
                if (stride_done)
                begin
                    state_next = S_SPATIAL;
                end
            end
            S_SPATIAL: state_next = S_WRITE;
            S_WRITE:   state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            few_reg       <= FEW_PC_RESET;
            many_reg      <= MANY_PC_RESET;
            win_reg       <= WINDOW_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + SAW'(1);
            end
            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FEW_PC:  few_reg  <= cfg_data;
                    CFG_MANY_PC: many_reg <= cfg_data;
                    CFG_WINDOW:  win_reg  <= cfg_data[WIN_W-1:0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && out_free)
        begin
            out_data_reg <= res_reg;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    req_reg  <= in_data;
                    set_reg  <= set_direct;
                    rem_reg  <= '0;
                    mcnt_reg <= MCW'(SET_IN_W - 1);
                end
            end
            S_MOD:
            begin
                rem_reg  <= rem_next;
                mcnt_reg <= mcnt_reg - MCW'(1);
                if (mcnt_reg == '0)
                begin
                    set_reg <= rem_next;
                end
            end
            S_LOAD:
            begin
                meta_reg <= mem_a_rdata;
                slot_reg <= mem_b_rdata;
            end
            S_PREP:
            begin
                scnt_reg    <= '0;
                wcnt_reg    <= '0;
                maxc_reg    <= CNT_W'(1);
                way_cnt_reg <= '0;
                hit_reg     <= 1'b0;
                free_reg    <= 1'b0;
                if (req_reg.command == CMD_FIND)
                begin
                    res_reg.victim_way         <= WAY_IN_W'(inv_way);
                    res_reg.victim_was_invalid <= inv_any;
                    if ((meta_reg.stride != '0) && (int'(uniq) < int'(few_reg)))
                    begin
                        wa_reg <= W_STRIDE_AGE;
                        ws_reg <= W_STRIDE_SP;
                        wp_reg <= W_STRIDE_PC;
                    end
                    else if (int'(uniq) > int'(many_reg))
                    begin
                        wa_reg <= W_MANY_AGE;
                        ws_reg <= W_MANY_SP;
                        wp_reg <= W_MANY_PC;
                    end
                    else
                    begin
                        wa_reg <= W_BASE;
                        ws_reg <= W_BASE;
                        wp_reg <= W_BASE;
                    end
                end
                else
                begin
                    res_reg <= '0;
                    if (!way_oob)
                    begin
                        for (int w = 0; w < WAYS; w++)
                        begin
                            if (WIW'(w) == way_sel)
                            begin
                                meta_reg.age[w] <= '0;
                            end
                            else if (meta_reg.age[w] != AGE_MAX)
                            begin
                                meta_reg.age[w] <= meta_reg.age[w] + AGE_W'(1);
                            end
                        end
                        meta_reg.valid[way_sel] <= 1'b1;
                        meta_reg.pc[way_sel]    <= req_reg.pc_low;
                        if (meta_reg.hcount >= HCW'(HISTORY_DEPTH))
                        begin
                            for (int i = 0; i < HISTORY_DEPTH - 1; i++)
                            begin
                                slot_reg.hist[i] <= slot_reg.hist[i+1];
                            end
                            slot_reg.hist[HISTORY_DEPTH-1] <= req_reg.address;
                        end
                        else
                        begin
                            slot_reg.hist[meta_reg.hcount[HIW-1:0]] <= req_reg.address;
                            meta_reg.hcount <= meta_reg.hcount + HCW'(1);
                        end
                    end
                end
            end
            S_SCAN:
            begin
                scnt_reg <= scan_last ? '0 : (scnt_reg + SIW'(1));
                if (req_reg.command == CMD_FIND)
                begin
                    if (meta_reg.used[scnt_reg] && (slot_reg.cnt[scnt_reg] > maxc_reg))
                    begin
                        maxc_reg <= slot_reg.cnt[scnt_reg];
                    end
                    for (int w = 0; w < WAYS; w++)
                    begin
                        if (meta_reg.used[scnt_reg]
                            && (slot_reg.key[scnt_reg] == meta_reg.pc[w]))
                        begin
                            way_cnt_reg[w] <= slot_reg.cnt[scnt_reg];
                        end
                    end
                end
                else
                begin
                    if (meta_reg.used[scnt_reg] && (slot_reg.key[scnt_reg] == req_reg.pc_low))
                    begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= scnt_reg;
                    end
                    if (!meta_reg.used[scnt_reg] && !free_reg)
                    begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= scnt_reg;
                    end
                    if ((scnt_reg == '0) || (slot_reg.cnt[scnt_reg] < minc_reg))
                    begin
                        minc_reg    <= slot_reg.cnt[scnt_reg];
                        min_idx_reg <= scnt_reg;
                    end
                end
            end
            S_SCORE:
            begin
                wcnt_reg <= wcnt_reg + WIW'(1);
                if ((wcnt_reg == '0) || (score > best_reg))
                begin
                    best_reg   <= score;
                    victim_reg <= wcnt_reg;
                end
                if (score_last)
                begin
                    res_reg.victim_was_invalid <= 1'b0;
                    if ((wcnt_reg == '0) || (score > best_reg))
                    begin
                        res_reg.victim_way <= WAY_IN_W'(wcnt_reg);
                    end
                    else
                    begin
                        res_reg.victim_way <= WAY_IN_W'(victim_reg);
                    end
                end
            end
            S_COUNT:
            begin
                if (hit_reg)
                begin
                    if (slot_reg.cnt[hit_idx_reg] != COUNT_MAX)
                    begin
                        slot_reg.cnt[hit_idx_reg] <= slot_reg.cnt[hit_idx_reg] + CNT_W'(1);
                    end
                end
                else if (free_reg)
                begin
                    meta_reg.used[free_idx_reg] <= 1'b1;
                    slot_reg.key[free_idx_reg]  <= req_reg.pc_low;
                    slot_reg.cnt[free_idx_reg]  <= CNT_W'(1);
                end
                else if (minc_reg <= CNT_W'(1))
                begin
                    slot_reg.key[min_idx_reg] <= req_reg.pc_low;
                    slot_reg.cnt[min_idx_reg] <= CNT_W'(1);
                end
                d_reg  <= {1'b0, slot_reg.hist[1]} - {1'b0, slot_reg.hist[0]};
                i_reg  <= HCW'(2);
                ok_reg <= 1'b1;
            end
            S_STRIDE:
            begin
                if (stride_done)
                begin
                    if ((meta_reg.hcount >= HCW'(3)) && ok_reg)
                    begin
                        meta_reg.stride <= d_reg[STRIDE_W-1:0];
                    end
                    else
                    begin
                        meta_reg.stride <= '0;
                    end
                end
                else
                begin
                    if (step_diff != d_reg)
                    begin
                        ok_reg <= 1'b0;
                    end
                    i_reg <= i_reg + HCW'(1);
                end
            end
            S_SPATIAL:
            begin
                meta_reg.spatial[way_sel] <= sp_code;
                meta_reg.last             <= req_reg.address;
            end
            default:
            begin
            end
        endcase
    end

    // pc rarity term never goes negative
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCORE) |-> (maxc_reg >= way_cnt_reg[wcnt_reg]))
        else $error("pc count above table maximum during way scan");

    // a new result only comes out of the completion state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion");

    // one request at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
        else $error("second beat taken while busy");

endmodule

### bench/stride_pc_hybrid_cache_replacement_tb.sv
// testbench for the stride and pc hybrid replacement policy with a scoreboard predictor
`timescale 1ns / 1ps

module stride_pc_hybrid_cache_replacement_tb;
    import sphcr_pkg::*;

    localparam int NSETS = SETS_DEF;
    localparam int NWAYS = WAYS_DEF;
    localparam int NHIST = HIST_DEF;
    localparam int NSLOT = SLOTS_DEF;
    localparam int PHASE_ITEMS = 360;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 120;
    localparam int WATCHDOG_LIMIT = 20000;

    class victim_scoreboard;
        bit          line_valid [NSETS*NWAYS];
        bit [7:0]    line_age [NSETS*NWAYS];
        bit [11:0]   line_pc [NSETS*NWAYS];
        bit [1:0]    line_sp [NSETS*NWAYS];
        bit [47:0]   hist [NSETS*NHIST];
        int          hist_len [NSETS];
        bit [31:0]   stride [NSETS];
        bit [47:0]   prev_addr [NSETS];
        bit [11:0]   slot_key [NSETS*NSLOT];
        int          slot_cnt [NSETS*NSLOT];
        bit [31:0]   slot_used [NSETS];
        int          few_pc;
        int          many_pc;
        int          window;
        rsp_t        expected_q[$];
        int          errors;
        int          checked;

        function new();
            foreach (line_age[i]) line_age[i] = 8'hFF;
            few_pc = int'(FEW_PC_RESET);
            many_pc = int'(MANY_PC_RESET);
            window = int'(WINDOW_RESET);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_FEW_PC) few_pc = int'(val);
            else if (idx == CFG_MANY_PC) many_pc = int'(val);
            else if (idx == CFG_WINDOW) window = int'(val[WIN_W-1:0]);
        endfunction

        function int slot_of(int set, bit [11:0] key);
            for (int s = 0; s < NSLOT; s++)
                if (slot_used[set][s] && slot_key[set*NSLOT+s] == key) return s;
            return -1;
        endfunction

        function rsp_t predict_find(int set);
            rsp_t r;
            int wa, ws, wp, maxc, uniq, c, sl, victim, best, score;
            r = '0;
            for (int w = 0; w < NWAYS; w++)
                if (!line_valid[set*NWAYS+w])
                begin
                    r.victim_way = WAY_IN_W'(w);
                    r.victim_was_invalid = 1'b1;
                    return r;
                end
            uniq = $countones(slot_used[set]);
            wa = 2; ws = 2; wp = 2;
            if (stride[set] != 0 && uniq < few_pc)
            begin
                wa = 3; ws = 4; wp = 1;
            end
            else if (uniq > many_pc)
            begin
                wa = 2; ws = 1; wp = 4;
            end
            maxc = 1;
            for (int s = 0; s < NSLOT; s++)
                if (slot_used[set][s] && slot_cnt[set*NSLOT+s] > maxc)
                    maxc = slot_cnt[set*NSLOT+s];
            best = -100000;
            victim = 0;
            for (int w = 0; w < NWAYS; w++)
            begin
                sl = slot_of(set, line_pc[set*NWAYS+w]);
                c = sl >= 0 ? slot_cnt[set*NSLOT+sl] : 0;
                score = wa*int'(line_age[set*NWAYS+w]) + ws*int'(line_sp[set*NWAYS+w])
                        + wp*(maxc - c);
                if (score > best)
                begin
                    best = score;
                    victim = w;
                end
            end
            r.victim_way = WAY_IN_W'(victim);
            return r;
        endfunction

        function void count_pc(int set, bit [11:0] key);
            int sl, b, bc;
            sl = slot_of(set, key);
            if (sl >= 0)
            begin
                if (slot_cnt[set*NSLOT+sl] < 65535) slot_cnt[set*NSLOT+sl]++;
                return;
            end
            for (int s = 0; s < NSLOT; s++)
                if (!slot_used[set][s])
                begin
                    slot_used[set][s] = 1'b1;
                    slot_key[set*NSLOT+s] = key;
                    slot_cnt[set*NSLOT+s] = 1;
                    return;
                end
            b = 0;
            bc = slot_cnt[set*NSLOT];
            for (int s = 1; s < NSLOT; s++)
                if (slot_cnt[set*NSLOT+s] < bc)
                begin
                    b = s;
                    bc = slot_cnt[set*NSLOT+s];
                end
            if (bc <= 1)
            begin
                slot_key[set*NSLOT+b] = key;
                slot_cnt[set*NSLOT+b] = 1;
            end
        endfunction

        function void apply_update(int set, int way, bit [47:0] addr, bit [11:0] pc);
            int h;
            longint d, st, gap;
            longint unsigned adist, ast;
            bit ok;
            line_valid[set*NWAYS+way] = 1'b1;
            line_pc[set*NWAYS+way] = pc;
            for (int w = 0; w < NWAYS; w++)
                if (line_age[set*NWAYS+w] != 8'hFF) line_age[set*NWAYS+w]++;
            line_age[set*NWAYS+way] = 8'd0;
            h = set*NHIST;
            if (hist_len[set] >= NHIST)
            begin
                for (int i = 0; i < NHIST-1; i++) hist[h+i] = hist[h+i+1];
                hist[h+NHIST-1] = addr;
            end
            else
            begin
                hist[h+hist_len[set]] = addr;
                hist_len[set]++;
            end
            stride[set] = 0;
            if (hist_len[set] >= 3)
            begin
                d = longint'(hist[h+1]) - longint'(hist[h]);
                ok = 1;
                for (int i = 2; i < hist_len[set]; i++)
                    if (longint'(hist[h+i]) - longint'(hist[h+i-1]) != d) ok = 0;
                if (ok) stride[set] = d[31:0];
            end
            count_pc(set, pc);
            line_sp[set*NWAYS+way] = SP_FAR;
            if (stride[set] != 0)
            begin
                st = longint'(signed'(stride[set]));
                gap = longint'(addr) - longint'(prev_addr[set]);
                adist = gap < 0 ? -gap : gap;
                ast = st < 0 ? -st : st;
                if (gap == st) line_sp[set*NWAYS+way] = SP_EXACT;
                else if (adist <= longint'(window) * ast) line_sp[set*NWAYS+way] = SP_NEAR;
            end
            prev_addr[set] = addr;
        endfunction

        function void note_request(req_t q);
            if (q.command == CMD_FIND)
                expected_q.insert(expected_q.size(), predict_find(int'(q.set_index)));
            else
            begin
                apply_update(int'(q.set_index), int'(q.way_index), q.address, q.pc_low);
                expected_q.insert(expected_q.size(), rsp_t'('0));
            end
        endfunction

        function void check_response(rsp_t got);
            rsp_t e;
            if (expected_q.size() == 0)
            begin
                $error("unexpected response beat %0h", got);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (got.victim_way !== e.victim_way)
            begin
                $error("victim_way expected %0d actual %0d", e.victim_way, got.victim_way);
                errors++;
            end
            if (got.victim_was_invalid !== e.victim_was_invalid)
            begin
                $error("victim_was_invalid expected %0d actual %0d",
                       e.victim_was_invalid, got.victim_was_invalid);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    req_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    rsp_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic hold_go = 1'b0;

    victim_scoreboard sb = new();
    int sent;
    int idle_cycles;
    int rx_cycle;
    int rx_gap;
    int hold_left;
    bit hold_done;
    int set_pool [8];

    stride_pc_hybrid_cache_replacement uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) sb.check_response(out_data);
    end

    // receiver: random stalls, calm stretches, one long hold-off on request
    always @(posedge clk)
    begin
        rx_cycle++;
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_go && !hold_done)
        begin
            hold_done = 1;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (rx_gap > 0)
        begin
            rx_gap--;
            out_stall <= 1'b1;
        end
        else if ((rx_cycle / 256) % 4 == 3)
            out_stall <= 1'b0;
        else if ($urandom % 100 < 70)
            out_stall <= 1'b0;
        else
        begin
            out_stall <= 1'b1;
            rx_gap = ($urandom % 100 < 92) ? $urandom_range(0, 2) : $urandom_range(15, 50);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout with %0d responses outstanding", sb.expected_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send(input req_t q);
        int r;
        in_valid <= 1'b1;
        in_data <= q;
        do @(posedge clk); while (in_stall);
        sb.note_request(q);
        sent++;
        r = $urandom % 100;
        if (sent % 200 < 40 || r < 60) return;
        in_valid <= 1'b0;
        repeat (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic req_t make_req(logic cmd, int set, int way, logic [47:0] addr,
                                      logic [11:0] pc);
        req_t q;
        q.command = cmd;
        q.set_index = SET_IN_W'(set);
        q.way_index = WAY_IN_W'(way);
        q.address = addr;
        q.pc_low = pc;
        return q;
    endfunction

    function automatic req_t any_req();
        return make_req(1'($urandom_range(0, 1)), $urandom_range(0, NSETS-1),
                        $urandom_range(0, 15), 48'({$urandom, $urandom}), 12'($urandom));
    endfunction

    task automatic stride_run();
        int set, n, pcs, way;
        logic [47:0] addr;
        longint step;
        logic [11:0] pc0;
        set = set_pool[$urandom_range(0, 7)];
        n = $urandom_range(4, 14);
        pcs = $urandom_range(1, 4);
        pc0 = 12'($urandom);
        addr = 48'({$urandom, $urandom});
        case ($urandom % 4)
            0: step = 64;
            1: step = -longint'($urandom_range(1, 4096));
            2: step = $urandom_range(1, 1 << 20);
            default: step = longint'($urandom) << $urandom_range(0, 3);
        endcase
        way = $urandom_range(0, 15);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom % 4 == 0) send(make_req(CMD_FIND, set, 0, 0, 0));
            if ($urandom % 8 == 0)
                send(make_req(CMD_UPDATE, set, way, addr + 48'($urandom_range(1, 300)), pc0));
            send(make_req(CMD_UPDATE, set, way, addr,
                          pc0 + 12'($urandom_range(0, pcs - 1))));
            addr = addr + 48'(step);
            way = ($urandom % 2) ? (way + 1) % 16 : $urandom_range(0, 15);
        end
        send(make_req(CMD_FIND, set, $urandom, 48'({$urandom, $urandom}), 12'($urandom)));
    endtask

    task automatic pc_flood();
        int set;
        set = set_pool[$urandom_range(0, 7)];
        for (int i = 0; i < 24; i++)
        begin
            send(make_req(CMD_UPDATE, set, $urandom_range(0, 15), 48'({$urandom, $urandom}),
                          12'($urandom)));
            if ($urandom % 3 == 0) send(make_req(CMD_FIND, set, 0, 0, 0));
        end
    endtask

    task automatic random_phase(input int target);
        int r;
        target = sent + target;
        while (sent < target)
        begin
            r = $urandom % 10;
            if (r < 7) stride_run();
            else if (r == 7) pc_flood();
            else send(any_req());
        end
    endtask

    initial
    begin
        set_pool[0] = 0;
        set_pool[1] = NSETS - 1;
        for (int i = 2; i < 8; i++) set_pool[i] = $urandom_range(0, NSETS - 1);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty set, extremes of every field, then a fully valid strided set
        send(make_req(CMD_FIND, 0, 0, 0, 0));
        send(make_req(CMD_UPDATE, 0, 15, 48'h0, 12'h000));
        send(make_req(CMD_FIND, 0, 15, '1, 12'hFFF));
        for (int w = 0; w < 15; w++)
            send(make_req(CMD_UPDATE, 0, w, 48'h1000 + 48'(64*w), w[0] ? 12'hFFF : 12'h000));
        send(make_req(CMD_FIND, 0, 0, 0, 0));
        send(make_req(CMD_UPDATE, NSETS - 1, 15, '1, 12'hFFF));
        send(make_req(CMD_FIND, NSETS - 1, 0, 0, 0));
        random_phase(PHASE_ITEMS - sent);
        drain();

        write_cfg(CFG_FEW_PC, 0);
        write_cfg(CFG_MANY_PC, 0);
        write_cfg(CFG_WINDOW, 1);
        random_phase(PHASE_ITEMS);
        drain();

        write_cfg(CFG_FEW_PC, 32);
        write_cfg(CFG_MANY_PC, 32);
        write_cfg(CFG_WINDOW, 15);
        hold_go <= 1'b1;
        random_phase(PHASE_ITEMS);
        drain();

        write_cfg(CFG_FEW_PC, CFG_DATA_W'($urandom_range(1, 31)));
        write_cfg(CFG_MANY_PC, CFG_DATA_W'($urandom_range(1, 31)));
        write_cfg(CFG_WINDOW, CFG_DATA_W'($urandom_range(2, 14)));
        random_phase(PHASE_ITEMS);
        drain();

        $display("sent %0d requests, checked %0d responses", sent, sb.checked);
        $display("covered strided sets, pc table overflow and four register settings");
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
